@@ src/kpi_pkg.sv @@
// shared types and codes for the keyframe pose interpolator
`default_nettype none

package kpi_pkg;

  localparam int NCH = 6;

  typedef enum logic [2:0] {
    ACT_KEY_VALUE  = 3'd0,
    ACT_KEY_LENGTH = 3'd1,
    ACT_KEY_COUNT  = 3'd2,
    ACT_REST       = 3'd3,
    ACT_START      = 3'd4,
    ACT_TICK       = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    RD_A = 2'd0,
    RD_B = 2'd1,
    RD_E = 2'd2,
    RD_F = 2'd3
  } rd_sel_e;

  typedef enum logic [1:0] {
    MUL_KEY  = 2'd0,
    MUL_NEXT = 2'd1,
    MUL_FADE = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [2:0]         motion_index;
    logic [3:0]         key_index;
    logic [3:0]         part_index;
    logic [2:0]         channel;
    logic signed [15:0] value;
    logic [7:0]         key_frames;
    logic [4:0]         key_count;
    logic               loop_flag;
    logic               blend_flag;
    logic [7:0]         blend_frames;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         part_number;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] ang_x;
    logic signed [15:0] ang_y;
    logic signed [15:0] ang_z;
    logic               done_res;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic     accept;
    logic     kl_next;
    logic     cap_klc;
    logic     cap_kln;
    logic     div_init;
    logic     div_step;
    rd_sel_e  rd_sel;
    logic     cap_a;
    logic     cap_b;
    logic     cap_e;
    logic     cap_f;
    mul_sel_e mul_sel;
    logic     add_x;
    logic     add_w;
    logic     fin;
    logic     adv;
  } kpi_cmd_t;

  typedef struct packed {
    logic run_req;
    logic div_done;
    logic blend_use;
    logic last_ch;
    logic last_part;
    logic plain;
  } kpi_stat_t;

endpackage

`default_nettype wire

@@ src/keyframe_pose_interpolator.sv @@
// top level of the keyframe pose interpolator
`default_nettype none

// Keyframe pose interpolator. Items are accepted when start is high and busy is low.
// Load items (key values, key lengths, key counts, rest offsets) and blended starts
// take effect in the accept cycle and produce nothing. A plain start or a tick emits
// one pose per part on result_o, each valid for exactly one cycle on result_valid_o;
// the receiver cannot stall, so it must take every strobe. After the accept edge a
// posing run is busy through setup (the key length reads, then a shared 16-step
// divider run three times for the key, incoming key and fade rates) and then, per
// channel of each part, through the key store reads and the lerp steps, more of them
// with a crossfade, set by the single read port of the key store and the single shared
// lerp multiplier; after a tick one more state follows that advances the motion.
// The key store, length store, rest offsets and key counts come up undefined and
// must be loaded before use; there is no clearing pass after reset.

module keyframe_pose_interpolator #(
  parameter int MAX_PARTS   = 16,
  parameter int MAX_MOTIONS = 8,
  parameter int MAX_KEYS    = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  kpi_pkg::in_item_t  item_i,
  input  wire                cfg_we_i,
  input  wire [4:0]          cfg_wdata_i,
  output kpi_pkg::out_item_t result_o,
  output logic               result_valid_o
);
  import kpi_pkg::*;

  // command and status between sequencer and datapath
  kpi_cmd_t  cmd;
  kpi_stat_t st;

  kpi_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .st_i   (st),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // stores, rate divider, lerp unit and the per-motion counters
  kpi_datapath #(
    .MAX_PARTS  (MAX_PARTS),
    .MAX_MOTIONS(MAX_MOTIONS),
    .MAX_KEYS   (MAX_KEYS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .st_o          (st),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

endmodule

`default_nettype wire

@@ src/kpi_ctrl.sv @@
// sequencing state machine for the keyframe pose interpolator
`default_nettype none

module kpi_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  input  kpi_pkg::kpi_stat_t st_i,
  output kpi_pkg::kpi_cmd_t  cmd_o,
  output logic               busy_o
);
  import kpi_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE = 17'b00000000000000001,
    S_KL0  = 17'b00000000000000010,
    S_KL1  = 17'b00000000000000100,
    S_KL2  = 17'b00000000000001000,
    S_DIV  = 17'b00000000000010000,
    S_RA   = 17'b00000000000100000,
    S_RB   = 17'b00000000001000000,
    S_RE   = 17'b00000000010000000,
    S_RF   = 17'b00000000100000000,
    S_M1   = 17'b00000001000000000,
    S_A1   = 17'b00000010000000000,
    S_M2   = 17'b00000100000000000,
    S_A2   = 17'b00001000000000000,
    S_M3   = 17'b00010000000000000,
    S_A3   = 17'b00100000000000000,
    S_FIN  = 17'b01000000000000000,
    S_ADV  = 17'b10000000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o         = '0;
    cmd_o.rd_sel  = RD_A;
    cmd_o.mul_sel = MUL_KEY;
    state_d       = state_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept = start_i;
        if (start_i && st_i.run_req) state_d = S_KL0;
      end
      S_KL0: state_d = S_KL1;
      S_KL1: begin
        cmd_o.kl_next = 1'b1;
        cmd_o.cap_klc = 1'b1;
        state_d       = S_KL2;
      end
      S_KL2: begin
        cmd_o.cap_kln  = 1'b1;
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        if (st_i.div_done) begin
          state_d = S_RA;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_RA: begin
        cmd_o.rd_sel = RD_A;
        state_d      = S_RB;
      end
      S_RB: begin
        cmd_o.rd_sel = RD_B;
        cmd_o.cap_a  = 1'b1;
        state_d      = S_RE;
      end
      S_RE: begin
        cmd_o.rd_sel = RD_E;
        cmd_o.cap_b  = 1'b1;
        state_d      = S_RF;
      end
      S_RF: begin
        cmd_o.rd_sel = RD_F;
        cmd_o.cap_e  = 1'b1;
        state_d      = S_M1;
      end
      S_M1: begin
        cmd_o.cap_f   = 1'b1;
        cmd_o.mul_sel = MUL_KEY;
        state_d       = S_A1;
      end
      S_A1: begin
        cmd_o.add_x = 1'b1;
        state_d     = st_i.blend_use ? S_M2 : S_FIN;
      end
      S_M2: begin
        cmd_o.mul_sel = MUL_NEXT;
        state_d       = S_A2;
      end
      S_A2: begin
        cmd_o.add_w = 1'b1;
        state_d     = S_M3;
      end
      S_M3: begin
        cmd_o.mul_sel = MUL_FADE;
        state_d       = S_A3;
      end
      S_A3: begin
        cmd_o.add_x = 1'b1;
        state_d     = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        if (!st_i.last_ch || !st_i.last_part) begin
          state_d = S_RA;
        end else begin
          state_d = st_i.plain ? S_IDLE : S_ADV;
        end
      end
      S_ADV: begin
        cmd_o.adv = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ src/kpi_datapath.sv @@
// stores, divider, lerp unit and motion state of the keyframe pose interpolator
`default_nettype none

module kpi_datapath #(
  parameter int MAX_PARTS   = 16,
  parameter int MAX_MOTIONS = 8,
  parameter int MAX_KEYS    = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  kpi_pkg::in_item_t  item_i,
  input  wire                cfg_we_i,
  input  wire [4:0]          cfg_wdata_i,
  input  kpi_pkg::kpi_cmd_t  cmd_i,
  output kpi_pkg::kpi_stat_t st_o,
  output kpi_pkg::out_item_t result_o,
  output logic               result_valid_o
);
  import kpi_pkg::*;

  localparam int KDEPTH = MAX_MOTIONS * MAX_KEYS * MAX_PARTS * NCH;
  localparam int KAW    = $clog2(KDEPTH);
  localparam int LDEPTH = MAX_MOTIONS * MAX_KEYS;
  localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int RDEPTH = MAX_PARTS * NCH;
  localparam int RAW    = $clog2(RDEPTH);
  localparam int MIW    = (MAX_MOTIONS > 1) ? $clog2(MAX_MOTIONS) : 1;
  localparam int KW     = $clog2(MAX_KEYS);
  localparam int KCW    = $clog2(MAX_KEYS + 1);
  localparam int NLIM   = (MAX_PARTS < 16) ? MAX_PARTS : 16;

  function automatic logic [KAW-1:0] kaddr(input logic [2:0] m, input logic [KW-1:0] k,
                                           input logic [3:0] p, input logic [2:0] c);
    kaddr = KAW'(((int'(m) * MAX_KEYS + int'(k)) * MAX_PARTS + int'(p)) * NCH + int'(c));
  endfunction

  function automatic logic [KCW-1:0] clamp_count(input logic [KCW-1:0] c);
    if (c == '0) clamp_count = KCW'(1);
    else if (int'(c) > MAX_KEYS) clamp_count = KCW'(MAX_KEYS);
    else clamp_count = c;
  endfunction

  // stores
  logic signed [15:0] key_mem [KDEPTH];
  logic [7:0]         len_mem [LDEPTH];
  logic signed [15:0] rest_mem [RDEPTH];
  logic [KCW-1:0]     kcnt_q [MAX_MOTIONS];

  logic [4:0] part_count_q;

  // motion state
  logic [2:0]     cur_motion_q, next_motion_q;
  logic [KW-1:0]  cur_key_q, next_key_q;
  logic [7:0]     cur_tick_q, next_tick_q, fade_tick_q, fade_len_q;
  logic [KCW-1:0] cur_cnt_q, next_cnt_q;
  logic           cur_loop_q, next_loop_q, finished_q, blending_q, plain_q;

  // run registers
  logic [3:0]  part_q;
  logic [2:0]  ch_q;
  logic [7:0]  klc_q, kln_q;
  logic [15:0] rk_q, rb_q, rf_q;
  logic signed [15:0] kd_q, rest_q, a_q, b_q, e_q, f_q, x_q, w_q, base_q;
  logic signed [33:0] prod_q;
  logic signed [15:0] v_q [NCH];
  logic [3:0]  opart_q;
  logic        odone_q, olast_q, emit_q;

  // divider
  logic [1:0]  dsel_q;
  logic [3:0]  dit_q;
  logic [7:0]  drem_q;
  logic [15:0] dquo_q;
  logic        dov_q, ddone_q;

  logic in_acc;
  logic m_ok, k_ok, p_ok, c_ok;
  logic [KCW-1:0] kc_in, kc_sel;

  assign in_acc = cmd_i.accept;
  assign m_ok   = int'(item_i.motion_index) < MAX_MOTIONS;
  assign k_ok   = int'(item_i.key_index) < MAX_KEYS;
  assign p_ok   = int'(item_i.part_index) < MAX_PARTS;
  assign c_ok   = int'(item_i.channel) < NCH;
  assign kc_in  = (int'(item_i.key_count) > MAX_KEYS) ? KCW'(MAX_KEYS) :
                  (item_i.key_count == '0) ? KCW'(1) : KCW'(item_i.key_count);
  assign kc_sel = clamp_count(kcnt_q[MIW'(item_i.motion_index)]);

  // effective part count
  logic [4:0] n_eff;
  always_comb begin
    if (part_count_q == '0) n_eff = 5'd1;
    else if (int'(part_count_q) > NLIM) n_eff = 5'(NLIM);
    else n_eff = part_count_q;
  end

  // key successors
  logic [KW-1:0] cn, bn;
  assign cn = ((KCW'(cur_key_q) + KCW'(1)) == cur_cnt_q) ? '0 : KW'(cur_key_q + 1'b1);
  assign bn = ((KCW'(next_key_q) + KCW'(1)) == next_cnt_q) ? '0 : KW'(next_key_q + 1'b1);

  // advance on a tick
  logic [8:0] ct1, nt1, ft1;
  logic       cwrap, nwrap, fdone, fin_new;
  assign ct1     = {1'b0, cur_tick_q} + 9'd1;
  assign nt1     = {1'b0, next_tick_q} + 9'd1;
  assign ft1     = {1'b0, fade_tick_q} + 9'd1;
  assign cwrap   = ct1 >= {1'b0, klc_q};
  assign nwrap   = nt1 >= {1'b0, kln_q};
  assign fdone   = ft1 >= {1'b0, fade_len_q};
  assign fin_new = blending_q ? (nwrap && bn == '0 && !next_loop_q)
                              : (cwrap && KCW'(cn) == cur_cnt_q - KCW'(1) && !cur_loop_q);

  assign st_o.run_req   = ((item_i.action == ACT_START) && m_ok && !item_i.blend_flag) ||
                          ((item_i.action == ACT_TICK) && !finished_q);
  assign st_o.div_done  = ddone_q;
  assign st_o.blend_use = blending_q && !plain_q;
  assign st_o.last_ch   = (int'(ch_q) == NCH - 1);
  assign st_o.last_part = ({1'b0, part_q} == n_eff - 5'd1);
  assign st_o.plain     = plain_q;

  // memories
  logic [KAW-1:0] k_raddr;
  logic [LAW-1:0] l_raddr;
  logic [RAW-1:0] r_raddr;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_A:    k_raddr = kaddr(cur_motion_q, cur_key_q, part_q, ch_q);
      RD_B:    k_raddr = kaddr(cur_motion_q, cn, part_q, ch_q);
      RD_E:    k_raddr = kaddr(next_motion_q, next_key_q, part_q, ch_q);
      RD_F:    k_raddr = kaddr(next_motion_q, bn, part_q, ch_q);
      default: k_raddr = '0;
    endcase
  end
  assign l_raddr = cmd_i.kl_next ? LAW'(int'(next_motion_q) * MAX_KEYS + int'(next_key_q))
                                 : LAW'(int'(cur_motion_q) * MAX_KEYS + int'(cur_key_q));
  assign r_raddr = RAW'(int'(part_q) * NCH + int'(ch_q));

  logic [7:0] kl_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && item_i.action == ACT_KEY_VALUE && m_ok && k_ok && p_ok && c_ok) begin
      key_mem[kaddr(item_i.motion_index, KW'(item_i.key_index), item_i.part_index,
                    item_i.channel)] <= item_i.value;
    end
    kd_q <= key_mem[k_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && item_i.action == ACT_KEY_LENGTH && m_ok && k_ok) begin
      len_mem[LAW'(int'(item_i.motion_index) * MAX_KEYS + int'(item_i.key_index))] <=
        (item_i.key_frames == '0) ? 8'd1 : item_i.key_frames;
    end
    kl_rd_q <= len_mem[l_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && item_i.action == ACT_REST && p_ok && c_ok) begin
      rest_mem[RAW'(int'(item_i.part_index) * NCH + int'(item_i.channel))] <= item_i.value;
    end
    rest_q <= rest_mem[r_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && item_i.action == ACT_KEY_COUNT && m_ok) begin
      kcnt_q[MIW'(item_i.motion_index)] <= kc_in;
    end
  end

  // divider operands
  logic [7:0] dl, dt_n, dl_n;
  always_comb begin
    unique case (dsel_q)
      2'd0:    dl = klc_q;
      2'd1:    dl = kln_q;
      default: dl = fade_len_q;
    endcase
    unique case (dsel_q)
      2'd0:    begin dt_n = next_tick_q; dl_n = kln_q;      end
      default: begin dt_n = fade_tick_q; dl_n = fade_len_q; end
    endcase
  end

  logic [8:0]  r2;
  logic        dge;
  logic [15:0] qfin;
  assign r2   = {drem_q, 1'b0};
  assign dge  = r2 >= {1'b0, dl};
  assign qfin = dov_q ? 16'hFFFF : {dquo_q[14:0], dge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ddone_q <= 1'b0;
      dsel_q  <= '0;
      dit_q   <= '0;
    end else if (cmd_i.div_init) begin
      ddone_q <= 1'b0;
      dsel_q  <= '0;
      dit_q   <= '0;
    end else if (cmd_i.div_step) begin
      dit_q <= dit_q + 4'd1;
      if (dit_q == 4'd15) begin
        if (dsel_q == 2'd2) ddone_q <= 1'b1;
        else dsel_q <= dsel_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      drem_q <= cur_tick_q;
      dov_q  <= cur_tick_q >= klc_q;
      dquo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (dit_q == 4'd15) begin
        unique case (dsel_q)
          2'd0:    rk_q <= qfin;
          2'd1:    rb_q <= qfin;
          default: rf_q <= qfin;
        endcase
        drem_q <= dt_n;
        dov_q  <= dt_n >= dl_n;
        dquo_q <= '0;
      end else begin
        drem_q <= dge ? 8'(r2 - {1'b0, dl}) : r2[7:0];
        dquo_q <= {dquo_q[14:0], dge};
      end
    end
  end

  // lerp unit: multiply stage, then round and add stage
  logic signed [15:0] ma, mb;
  logic [15:0]        mr;
  logic               ang;
  logic signed [16:0] dd;
  logic signed [15:0] dw;
  logic signed [33:0] t34;
  logic signed [15:0] lres;

  assign ang = ch_q >= 3'd3;
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_KEY:  begin ma = a_q; mb = b_q; mr = rk_q; end
      MUL_NEXT: begin ma = e_q; mb = f_q; mr = rb_q; end
      default:  begin ma = x_q; mb = w_q; mr = rf_q; end
    endcase
  end
  assign dw   = mb - ma;
  assign dd   = ang ? {dw[15], dw} : ({mb[15], mb} - {ma[15], ma});
  assign t34  = prod_q + 34'sd32768;
  assign lres = base_q + t34[31:16];

  // rest offset, saturated or wrapped
  logic signed [16:0] s17;
  logic signed [15:0] fval;
  assign s17 = {x_q[15], x_q} + {rest_q[15], rest_q};
  always_comb begin
    if (ang) fval = s17[15:0];
    else if (s17 > 17'sd32767) fval = 16'sh7FFF;
    else if (s17 < -17'sd32768) fval = -16'sh8000;
    else fval = s17[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_klc) klc_q <= kl_rd_q;
    if (cmd_i.cap_kln) kln_q <= kl_rd_q;
    if (cmd_i.cap_a) a_q <= kd_q;
    if (cmd_i.cap_b) b_q <= kd_q;
    if (cmd_i.cap_e) e_q <= kd_q;
    if (cmd_i.cap_f) f_q <= kd_q;
    prod_q <= dd * $signed({1'b0, mr});
    base_q <= ma;
    if (cmd_i.add_x) x_q <= lres;
    if (cmd_i.add_w) w_q <= lres;
    if (cmd_i.fin) begin
      v_q[ch_q] <= fval;
      opart_q   <= part_q;
      olast_q   <= st_o.last_part;
      odone_q   <= plain_q ? 1'b0 : fin_new;
    end
  end

  // control and motion state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_count_q  <= 5'd1;
      cur_motion_q  <= '0;
      cur_key_q     <= '0;
      cur_tick_q    <= '0;
      cur_cnt_q     <= KCW'(1);
      cur_loop_q    <= 1'b0;
      finished_q    <= 1'b1;
      blending_q    <= 1'b0;
      next_motion_q <= '0;
      next_key_q    <= '0;
      next_tick_q   <= '0;
      next_cnt_q    <= KCW'(1);
      next_loop_q   <= 1'b0;
      fade_tick_q   <= '0;
      fade_len_q    <= 8'd1;
      plain_q       <= 1'b0;
      part_q        <= '0;
      ch_q          <= '0;
      emit_q        <= 1'b0;
    end else begin
      emit_q <= cmd_i.fin && st_o.last_ch;
      if (cfg_we_i) part_count_q <= cfg_wdata_i;
      if (in_acc) begin
        part_q <= '0;
        ch_q   <= '0;
        if (item_i.action == ACT_START && m_ok) begin
          finished_q <= 1'b0;
          plain_q    <= 1'b1;
          if (item_i.blend_flag) begin
            blending_q    <= 1'b1;
            fade_len_q    <= (item_i.blend_frames == '0) ? 8'd1 : item_i.blend_frames;
            fade_tick_q   <= '0;
            next_motion_q <= item_i.motion_index;
            next_loop_q   <= item_i.loop_flag;
            next_cnt_q    <= kc_sel;
            next_key_q    <= '0;
            next_tick_q   <= '0;
          end else begin
            cur_motion_q <= item_i.motion_index;
            cur_cnt_q    <= kc_sel;
            cur_loop_q   <= item_i.loop_flag;
            cur_key_q    <= '0;
            cur_tick_q   <= '0;
          end
        end else if (item_i.action == ACT_TICK) begin
          plain_q <= 1'b0;
        end
      end
      if (cmd_i.fin) begin
        if (st_o.last_ch) begin
          ch_q   <= '0;
          part_q <= part_q + 4'd1;
        end else begin
          ch_q <= ch_q + 3'd1;
        end
      end
      if (cmd_i.adv) begin
        finished_q <= fin_new;
        if (blending_q) begin
          next_tick_q <= nwrap ? 8'd0 : nt1[7:0];
          if (nwrap) next_key_q <= bn;
          if (fdone) begin
            fade_tick_q  <= '0;
            blending_q   <= 1'b0;
            cur_motion_q <= next_motion_q;
            cur_tick_q   <= nwrap ? 8'd0 : nt1[7:0];
            cur_cnt_q    <= next_cnt_q;
            cur_key_q    <= nwrap ? bn : next_key_q;
            cur_loop_q   <= next_loop_q;
          end else begin
            fade_tick_q <= ft1[7:0];
          end
        end else begin
          cur_tick_q <= cwrap ? 8'd0 : ct1[7:0];
          if (cwrap) cur_key_q <= cn;
        end
      end
    end
  end

  assign result_valid_o       = emit_q;
  assign result_o.part_number = opart_q;
  assign result_o.pos_x       = v_q[0];
  assign result_o.pos_y       = v_q[1];
  assign result_o.pos_z       = v_q[2];
  assign result_o.ang_x       = v_q[3];
  assign result_o.ang_y       = v_q[4];
  assign result_o.ang_z       = v_q[5];
  assign result_o.done_res    = odone_q;
  assign result_o.last        = olast_q;

endmodule

`default_nettype wire

@@ test/kpi_checker.sv @@
// checker for the keyframe pose interpolator: watches the ports, predicts poses, compares
`timescale 1ns / 1ps

module kpi_checker (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  input  wire                busy,
  input  kpi_pkg::in_item_t  item_i,
  input  wire                cfg_we_i,
  input  wire [4:0]          cfg_wdata_i,
  input  kpi_pkg::out_item_t result_o,
  input  wire                result_valid_o,
  output int                 fail_count,
  output int                 pending_count,
  output int                 item_count,
  output int                 pose_count
);
  import kpi_pkg::*;

  localparam int PARTS   = 16;
  localparam int MOTIONS = 8;
  localparam int KEYS    = 16;

  int key_mem  [MOTIONS*KEYS*PARTS*NCH];
  int len_mem  [MOTIONS*KEYS];
  int count_mem[MOTIONS];
  int rest_mem [PARTS*NCH];
  int parts_reg;
  int cm, ck_r, ct, ckc, cl, fin, blend;
  int nm, nk, nt, nkc, nl, ft, fl;

  out_item_t pose_q[$];

  function automatic int wrap16(int x);
    logic signed [15:0] t;
    t = x[15:0];
    return int'(t);
  endfunction

  function automatic int sat16(int x);
    return x > 32767 ? 32767 : (x < -32768 ? -32768 : x);
  endfunction

  function automatic int lerp(int a, int d, int rate);
    longint t;
    t = longint'(d) * longint'(rate) + 64'sd32768;
    return a + int'(t >>> 16);
  endfunction

  function automatic int qrate(int tick, int len);
    int r;
    if (len == 0) len = 1;
    r = (tick * 65536) / len;
    return r > 65535 ? 65535 : r;
  endfunction

  function automatic int mix(int a, int b, int rate, int ch);
    if (ch < 3) return lerp(a, b - a, rate);
    return wrap16(lerp(a, wrap16(b - a), rate));
  endfunction

  function automatic int clamp_count(int c);
    if (c < 1) c = 1;
    if (c > KEYS) c = KEYS;
    return c;
  endfunction

  function automatic int key_len(int m, int k);
    int l;
    l = len_mem[m*KEYS + k];
    return l == 0 ? 1 : l;
  endfunction

  function automatic int key_at(int m, int k, int p, int c);
    return key_mem[((m*KEYS + k)*PARTS + p)*NCH + c];
  endfunction

  function automatic int eff_parts();
    int n;
    n = parts_reg;
    if (n < 1) n = 1;
    if (n > PARTS) n = PARTS;
    return n;
  endfunction

  function automatic out_item_t make_pose(int p, int n, int v[NCH]);
    out_item_t o;
    int r[NCH];
    for (int c = 0; c < NCH; c++) begin
      r[c] = c < 3 ? sat16(v[c] + rest_mem[p*NCH + c]) : wrap16(v[c] + rest_mem[p*NCH + c]);
    end
    o.part_number = p[3:0];
    o.pos_x = r[0][15:0];
    o.pos_y = r[1][15:0];
    o.pos_z = r[2][15:0];
    o.ang_x = r[3][15:0];
    o.ang_y = r[4][15:0];
    o.ang_z = r[5][15:0];
    o.done_res = 1'b0;
    o.last = (p + 1 == n);
    return o;
  endfunction

  task automatic predict_poses(in_item_t it);
    int m, k, p, ch, n, cur, cnx, rk, bk, bn, rb, rf, x, w, base;
    int v[NCH];
    out_item_t o;
    m = it.motion_index;
    k = it.key_index;
    p = it.part_index;
    ch = it.channel;
    n = eff_parts();
    case (it.action)
      ACT_KEY_VALUE: if (ch < NCH) key_mem[((m*KEYS + k)*PARTS + p)*NCH + ch] = int'(it.value);
      ACT_KEY_LENGTH: len_mem[m*KEYS + k] = it.key_frames == 0 ? 1 : int'(it.key_frames);
      ACT_KEY_COUNT: count_mem[m] = clamp_count(int'(it.key_count));
      ACT_REST: if (ch < NCH) rest_mem[p*NCH + ch] = int'(it.value);
      ACT_START: begin
        if (it.blend_flag) begin
          blend = 1;
          fl = it.blend_frames == 0 ? 1 : int'(it.blend_frames);
          ft = 0;
          nm = m;
          nl = it.loop_flag;
          nkc = clamp_count(count_mem[m]);
          nk = 0;
          nt = 0;
          fin = 0;
        end else begin
          cm = m;
          ckc = clamp_count(count_mem[m]);
          cl = it.loop_flag;
          ck_r = 0;
          ct = 0;
          fin = 0;
          for (int i = 0; i < n; i++) begin
            for (int c = 0; c < NCH; c++) v[c] = key_at(m, 0, i, c);
            pose_q.push_back(make_pose(i, n, v));
          end
        end
      end
      ACT_TICK: begin
        if (!fin) begin
          base = pose_q.size();
          cur = ck_r % ckc;
          cnx = (cur + 1) % ckc;
          rk = qrate(ct, key_len(cm, cur));
          bk = nk % nkc;
          bn = (bk + 1) % nkc;
          rb = qrate(nt, key_len(nm, bk));
          rf = qrate(ft, fl);
          for (int i = 0; i < n; i++) begin
            for (int c = 0; c < NCH; c++) begin
              x = mix(key_at(cm, cur, i, c), key_at(cm, cnx, i, c), rk, c);
              if (blend) begin
                w = mix(key_at(nm, bk, i, c), key_at(nm, bn, i, c), rb, c);
                x = mix(x, w, rf, c);
              end
              v[c] = x;
            end
            pose_q.push_back(make_pose(i, n, v));
          end
          if (blend) begin
            nt++;
            if (nt >= key_len(nm, bk)) begin
              nt = 0;
              nk = (bk + 1) % nkc;
              if (nk == 0 && !nl) fin = 1;
            end
            ft++;
            if (ft >= fl) begin
              ft = 0;
              cm = nm;
              ct = nt;
              ckc = nkc;
              ck_r = nk;
              cl = nl;
              blend = 0;
            end
          end else begin
            ct++;
            if (ct >= key_len(cm, cur)) begin
              ct = 0;
              ck_r = (cur + 1) % ckc;
              if (ck_r == ckc - 1 && !cl) fin = 1;
            end
          end
          // done flag reflects the state after this tick
          for (int i = base; i < pose_q.size(); i++) pose_q[i].done_res = fin[0];
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_pose(out_item_t got);
    out_item_t exp_pose;
    if (pose_q.size() == 0) begin
      $error("pose for part %0d with nothing expected", got.part_number);
      fail_count++;
      return;
    end
    exp_pose = pose_q.pop_front();
    if (got.part_number !== exp_pose.part_number) begin
      $error("part_number expected %0d got %0d", exp_pose.part_number, got.part_number);
      fail_count++;
    end
    if (got.pos_x !== exp_pose.pos_x) begin
      $error("pos_x expected %0d got %0d", exp_pose.pos_x, got.pos_x);
      fail_count++;
    end
    if (got.pos_y !== exp_pose.pos_y) begin
      $error("pos_y expected %0d got %0d", exp_pose.pos_y, got.pos_y);
      fail_count++;
    end
    if (got.pos_z !== exp_pose.pos_z) begin
      $error("pos_z expected %0d got %0d", exp_pose.pos_z, got.pos_z);
      fail_count++;
    end
    if (got.ang_x !== exp_pose.ang_x) begin
      $error("ang_x expected %0d got %0d", exp_pose.ang_x, got.ang_x);
      fail_count++;
    end
    if (got.ang_y !== exp_pose.ang_y) begin
      $error("ang_y expected %0d got %0d", exp_pose.ang_y, got.ang_y);
      fail_count++;
    end
    if (got.ang_z !== exp_pose.ang_z) begin
      $error("ang_z expected %0d got %0d", exp_pose.ang_z, got.ang_z);
      fail_count++;
    end
    if (got.done_res !== exp_pose.done_res) begin
      $error("done_res expected %0d got %0d", exp_pose.done_res, got.done_res);
      fail_count++;
    end
    if (got.last !== exp_pose.last) begin
      $error("last expected %0d got %0d", exp_pose.last, got.last);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    item_count = 0;
    pose_count = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parts_reg = 1;
      cm = 0; ck_r = 0; ct = 0; ckc = 1; cl = 0; fin = 1; blend = 0;
      nm = 0; nk = 0; nt = 0; nkc = 1; nl = 0; ft = 0; fl = 1;
      pose_q.delete();
      pending_count <= 0;
    end else begin
      if (result_valid_o) begin
        pose_count++;
        compare_pose(result_o);
      end
      if (start && !busy) begin
        item_count++;
        predict_poses(item_i);
      end
      if (cfg_we_i) parts_reg = cfg_wdata_i;
      pending_count <= pose_q.size();
    end
  end

endmodule

@@ test/keyframe_pose_interpolator_test.sv @@
// testbench top for the keyframe pose interpolator: stimulus, config phases and verdict
`timescale 1ns / 1ps

module keyframe_pose_interpolator_test;
  import kpi_pkg::*;

  // action codes the block must ignore
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;
  // longest posing run, sixteen parts with a crossfade, rounded up for the settle wait
  localparam int SETTLE = 1600;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  item_i = '0;
  logic      cfg_we_i = 1'b0;
  logic [4:0] cfg_wdata_i = 5'd0;
  out_item_t result_o;
  logic      result_valid_o;

  int fail_count, pending_count, item_count, pose_count;
  int burst_left;
  int cfg_writes;

  always #5 clk_i = ~clk_i;

  keyframe_pose_interpolator dut (
    .clk_i, .rst_ni, .start, .busy, .item_i,
    .cfg_we_i, .cfg_wdata_i, .result_o, .result_valid_o
  );

  kpi_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .item_i,
    .cfg_we_i, .cfg_wdata_i, .result_o, .result_valid_o,
    .fail_count, .pending_count, .item_count, .pose_count
  );

  // every field random, so all bits of every field get toggled
  function automatic in_item_t noise_item();
    in_item_t it;
    logic [63:0] r;
    r = {$urandom, $urandom};
    it = r[$bits(in_item_t)-1:0];
    return it;
  endfunction

  // hand one item over; start stays high within a burst, else a random idle gap follows
  task automatic send_item(in_item_t it);
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // bursts of random length with random idle gaps in between
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 8);
      if ($urandom_range(0, 5) == 0) burst_left = 40;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0 || busy) @(posedge clk_i);
  endtask

  // part count only changes while idle: drain, then let any silent work finish
  task automatic set_parts(logic [4:0] v);
    drain();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic send_fields(logic [2:0] a, int m, int k, int p, int ch, int val);
    in_item_t it;
    it = noise_item();
    it.action = a;
    it.motion_index = m[2:0];
    it.key_index = k[3:0];
    it.part_index = p[3:0];
    it.channel = ch[2:0];
    it.value = val[15:0];
    send_item(it);
  endtask

  task automatic send_count(int m, int cnt);
    in_item_t it;
    it = noise_item();
    it.action = ACT_KEY_COUNT;
    it.motion_index = m[2:0];
    it.key_count = cnt[4:0];
    send_item(it);
  endtask

  task automatic send_start(int m, bit blend_on, bit loop_on, int blen);
    in_item_t it;
    it = noise_item();
    it.action = ACT_START;
    it.motion_index = m[2:0];
    it.blend_flag = blend_on;
    it.loop_flag = loop_on;
    it.blend_frames = blen[7:0];
    send_item(it);
  endtask

  task automatic send_length(int m, int k, int len);
    in_item_t it;
    it = noise_item();
    it.action = ACT_KEY_LENGTH;
    it.motion_index = m[2:0];
    it.key_index = k[3:0];
    it.key_frames = len[7:0];
    send_item(it);
  endtask

  task automatic send_tick();
    in_item_t it;
    it = noise_item();
    it.action = ACT_TICK;
    send_item(it);
  endtask

  // mostly well-formed traffic: ticks and starts, with loads and noise mixed in;
  // starts stay on motion 0 with at most two keys, the only poses that are loaded
  task automatic random_item();
    in_item_t it;
    int pick;
    it = noise_item();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.action = ACT_TICK;
    end else if (pick < 60) begin
      it.action = ACT_START;
      it.motion_index = 3'd0;
      if ($urandom_range(0, 3) != 0) it.blend_frames = 8'($urandom_range(0, 6));
    end else if (pick < 70) begin
      it.action = ACT_KEY_VALUE;
      if ($urandom_range(0, 3) != 0) it.channel = 3'($urandom_range(0, NCH - 1));
    end else if (pick < 76) begin
      it.action = ACT_KEY_LENGTH;
      if ($urandom_range(0, 4) != 0) it.key_frames = 8'($urandom_range(0, 5));
    end else if (pick < 80) begin
      it.action = ACT_KEY_COUNT;
      it.key_count = 5'($urandom_range(0, 2));
    end else if (pick < 88) begin
      it.action = ACT_REST;
      if ($urandom_range(0, 3) != 0) it.channel = 3'($urandom_range(0, NCH - 1));
    end else if (pick < 94) begin
      it.action = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
    end
    send_item(it);
  endtask

  initial begin
    burst_left = 0;
    cfg_writes = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // load motion 0's key count, key lengths, keys 0 and 1 and every rest offset, back to back
    burst_left = 1 << 30;
    send_count(0, 2);
    send_length(0, 0, $urandom_range(1, 4));
    send_length(0, 1, $urandom_range(1, 4));
    for (int p = 0; p < 16; p++)
      for (int c = 0; c < NCH; c++) send_fields(ACT_REST, 0, 0, p, c, $urandom_range(0, 400) - 200);
    for (int k = 0; k < 2; k++)
      for (int p = 0; p < 16; p++)
        for (int c = 0; c < NCH; c++) send_fields(ACT_KEY_VALUE, 0, k, p, c, $urandom);
    burst_left = 0;

    // directed part with two parts posed
    set_parts(5'd2);
    // saturation on part 0 x and part 1 y, angle wrap on part 0 z
    send_fields(ACT_KEY_VALUE, 0, 0, 0, 0, 32767);
    send_fields(ACT_REST, 0, 0, 0, 0, 32767);
    send_fields(ACT_KEY_VALUE, 0, 0, 1, 1, -32768);
    send_fields(ACT_REST, 0, 0, 1, 1, -32768);
    send_fields(ACT_KEY_VALUE, 0, 0, 0, 5, 32767);
    send_fields(ACT_REST, 0, 0, 0, 5, 32767);
    send_length(0, 0, 4);
    send_start(0, 1'b0, 1'b0, 1);
    send_tick();
    send_tick();
    // key length reloaded below the running tick
    send_length(0, 0, 1);
    send_tick();
    // crossfade, plain start while fading, then run out
    send_start(0, 1'b1, 1'b0, 3);
    send_tick();
    send_start(0, 1'b0, 1'b1, 0);
    repeat (4) send_tick();
    // zero lengths and counts, ignored items, tick after finish
    send_length(0, 1, 0);
    send_count(0, 0);
    send_fields(ACT_REST, 0, 0, 0, 7, 5);
    send_fields(ACT_SPARE_A, 0, 0, 0, 0, 0);
    send_start(0, 1'b1, 1'b0, 0);
    repeat (3) send_tick();

    // random phases with different part counts, extremes included
    set_parts(5'd16);
    repeat (15) random_item();
    // pause until everything has drained, then resume
    drain();
    set_parts(5'd31);
    repeat (10) random_item();
    set_parts(5'd0);
    repeat (15) random_item();
    set_parts(5'd1);
    repeat (20) random_item();
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      set_parts(5'($urandom_range(2, 6)));
      repeat (8) random_item();
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    $display("covered %0d items, %0d poses checked, %0d part count settings",
             item_count, pose_count, cfg_writes);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
